/* hdl/smap_pkg.sv */
package smap_pkg;

	localparam int unsigned HEADER_BYTES = 20;
	localparam logic [12:0] BODY_LIMIT = 13'd4096;
	localparam logic [31:0] MAGIC_COOKIE = 32'h2112A442;
	localparam logic [15:0] TYPE_MAPPED = 16'h0001;
	localparam logic [15:0] TYPE_XOR_MAPPED = 16'h0020;
	localparam logic [7:0] FAMILY_IPV4 = 8'h01;

	typedef enum logic [1:0] {
		ST_FOUND      = 2'd0,
		ST_NONE       = 2'd1,
		ST_BAD_LENGTH = 2'd2,
		ST_OVERRUN    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_HEADER = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		OC_PENDING = 2'd0,
		OC_FOUND   = 2'd1,
		OC_OVERRUN = 2'd2,
		OC_NONE    = 2'd3
	} outcome_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] public_address;
		logic [15:0] mapped_port;
	} out_t;

endpackage

/* hdl/stun_mapped_address_parser.sv */
// Once the request carrying the last byte of its message is accepted, a result is
// presented through the input register, then the result register.
// Throughput: one byte per cycle; a waiting result does not block input until
// both the input register and the result register are full.
// Reset clears the parser to idle and sets the body length limit to 4096.
module stun_mapped_address_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  smap_pkg::in_t       in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output smap_pkg::out_t      out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [12:0]         cfg_data
);

	logic [12:0]         max_body_length_q;
	logic                valid_s1;
	smap_pkg::in_t       data_s1;
	logic                out_valid_q;
	smap_pkg::out_t      out_q;
	logic                advance;

	smap_pkg::phase_t    phase_q, nxt_phase;
	smap_pkg::outcome_t  outcome_q, nxt_outcome;
	logic [12:0]         byte_pos_q, nxt_byte_pos;
	logic [12:0]         attr_pos_q, nxt_attr_pos;
	logic [15:0]         body_len_q, nxt_body_len;
	logic [31:0]         cookie_q, nxt_cookie;
	logic [15:0]         attr_type_q, nxt_attr_type;
	logic [15:0]         attr_len_q, nxt_attr_len;
	logic [15:0]         port_q, nxt_port;
	logic [31:0]         addr_q, nxt_addr;

	logic                emit;
	smap_pkg::status_t   emit_status;

	logic [12:0]         limit;
	logic [15:0]         remaining;
	logic [16:0]         attr_total;
	logic                stop;
	smap_pkg::phase_t    cur_phase;
	logic [12:0]         cur_pos;
	smap_pkg::outcome_t  cur_outcome;
	logic [7:0]          d;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign limit = (max_body_length_q > smap_pkg::BODY_LIMIT) ?
		smap_pkg::BODY_LIMIT : max_body_length_q;

	always_comb begin
		nxt_phase = phase_q;
		nxt_outcome = outcome_q;
		nxt_byte_pos = byte_pos_q;
		nxt_attr_pos = attr_pos_q;
		nxt_body_len = body_len_q;
		nxt_cookie = cookie_q;
		nxt_attr_type = attr_type_q;
		nxt_attr_len = attr_len_q;
		nxt_port = port_q;
		nxt_addr = addr_q;
		emit = 1'b0;
		emit_status = smap_pkg::ST_NONE;
		stop = 1'b0;
		attr_total = '0;
		d = data_s1.data_byte;
		cur_phase = phase_q;
		cur_pos = byte_pos_q;
		cur_outcome = outcome_q;
		remaining = body_len_q - {3'b000, byte_pos_q};
		if (data_s1.first_byte) begin
			cur_phase = smap_pkg::PH_HEADER;
			cur_pos = '0;
			cur_outcome = smap_pkg::OC_PENDING;
			nxt_outcome = smap_pkg::OC_PENDING;
		end
		unique case (cur_phase)
			smap_pkg::PH_IDLE: begin
				nxt_phase = smap_pkg::PH_IDLE;
			end
			smap_pkg::PH_HEADER: begin
				if (cur_pos == 13'd2) begin
					nxt_body_len[15:8] = d;
				end else if (cur_pos == 13'd3) begin
					nxt_body_len[7:0] = d;
				end else if (cur_pos >= 13'd4 && cur_pos <= 13'd7) begin
					nxt_cookie = {cookie_q[23:0], d};
				end
				if (cur_pos != 13'(smap_pkg::HEADER_BYTES - 1)) begin
					nxt_phase = smap_pkg::PH_HEADER;
					nxt_byte_pos = cur_pos + 13'd1;
				end else if (nxt_body_len == 16'd0 ||
						nxt_body_len > {3'b000, limit}) begin
					emit = 1'b1;
					emit_status = smap_pkg::ST_BAD_LENGTH;
					nxt_phase = smap_pkg::PH_IDLE;
					nxt_byte_pos = cur_pos;
				end else begin
					nxt_phase = smap_pkg::PH_BODY;
					nxt_byte_pos = '0;
					nxt_attr_pos = '0;
					nxt_outcome = smap_pkg::OC_PENDING;
				end
			end
			smap_pkg::PH_BODY: begin
				if (cur_outcome == smap_pkg::OC_PENDING) begin
					if (attr_pos_q == 13'd0 && remaining < 16'd4) begin
						nxt_outcome = smap_pkg::OC_NONE;
						stop = 1'b1;
					end else begin
						case (attr_pos_q) inside
							13'd0: nxt_attr_type = {d, 8'h00};
							13'd1: nxt_attr_type = {attr_type_q[15:8], d};
							13'd2: nxt_attr_len = {d, 8'h00};
							13'd3: begin
								nxt_attr_len = {attr_len_q[15:8], d};
								if (nxt_attr_len > remaining - 16'd1) begin
									nxt_outcome = smap_pkg::OC_OVERRUN;
									stop = 1'b1;
								end
							end
							13'd5: begin
								if (d != smap_pkg::FAMILY_IPV4) begin
									nxt_attr_type = '0;
								end
							end
							13'd6: nxt_port = {d, 8'h00};
							13'd7: nxt_port = {port_q[15:8], d};
							[13'd8:13'd11]: nxt_addr = {addr_q[23:0], d};
							default: ;
						endcase
						if (!stop) begin
							attr_total = 17'd4 +
								(({1'b0, nxt_attr_len} + 17'd3) & ~17'd3);
							if (attr_pos_q == 13'd11 && nxt_attr_len >= 16'd8 &&
									(nxt_attr_type == smap_pkg::TYPE_MAPPED ||
									nxt_attr_type == smap_pkg::TYPE_XOR_MAPPED)) begin
								if (nxt_attr_type == smap_pkg::TYPE_XOR_MAPPED) begin
									nxt_port = nxt_port ^ smap_pkg::MAGIC_COOKIE[31:16];
									nxt_addr = nxt_addr ^ cookie_q;
								end
								nxt_outcome = smap_pkg::OC_FOUND;
							end else if (attr_pos_q >= 13'd3) begin
								if ({4'b0000, attr_pos_q} + 17'd1 >= attr_total) begin
									nxt_attr_pos = '0;
								end else begin
									nxt_attr_pos = attr_pos_q + 13'd1;
								end
							end else begin
								nxt_attr_pos = attr_pos_q + 13'd1;
							end
						end
					end
				end
				if ({3'b000, byte_pos_q} + 16'd1 >= body_len_q) begin
					emit = 1'b1;
					nxt_phase = smap_pkg::PH_IDLE;
					if (nxt_outcome == smap_pkg::OC_FOUND) begin
						emit_status = smap_pkg::ST_FOUND;
					end else if (nxt_outcome == smap_pkg::OC_OVERRUN) begin
						emit_status = smap_pkg::ST_OVERRUN;
					end else begin
						emit_status = smap_pkg::ST_NONE;
					end
				end else begin
					nxt_phase = smap_pkg::PH_BODY;
					nxt_byte_pos = byte_pos_q + 13'd1;
				end
			end
			default: begin
				nxt_phase = smap_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_length_q <= smap_pkg::BODY_LIMIT;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q <= smap_pkg::PH_IDLE;
			outcome_q <= smap_pkg::OC_PENDING;
			byte_pos_q <= '0;
			attr_pos_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_body_length_q <= cfg_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				phase_q <= nxt_phase;
				outcome_q <= nxt_outcome;
				byte_pos_q <= nxt_byte_pos;
				attr_pos_q <= nxt_attr_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
		if (advance) begin
			body_len_q <= nxt_body_len;
			cookie_q <= nxt_cookie;
			attr_type_q <= nxt_attr_type;
			attr_len_q <= nxt_attr_len;
			port_q <= nxt_port;
			addr_q <= nxt_addr;
		end
		if (advance && emit) begin
			out_q.status <= emit_status;
			out_q.public_address <= (emit_status == smap_pkg::ST_FOUND) ? nxt_addr : '0;
			out_q.mapped_port <= (emit_status == smap_pkg::ST_FOUND) ? nxt_port : '0;
		end
	end

endmodule

/* verif/smap_checker.sv */
module smap_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  smap_pkg::in_t    in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  smap_pkg::out_t   out_data,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [12:0]      cfg_data,
	output int               pending_results,
	output int               error_count,
	output int               results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	smap_pkg::phase_t    phase;
	smap_pkg::outcome_t  outcome;
	logic [12:0]         limit;
	logic [12:0]         byte_pos;
	logic [15:0]         body_len;
	logic [31:0]         cookie;
	logic [15:0]         attr_pos;
	logic [15:0]         attr_type;
	logic [15:0]         attr_len;
	logic [15:0]         cap_port;
	logic [31:0]         cap_addr;
	smap_pkg::out_t      parsed_results[$];

	function automatic void clear_message();
		byte_pos = '0;
		body_len = '0;
		cookie = '0;
		attr_pos = '0;
		attr_type = '0;
		attr_len = '0;
		cap_port = '0;
		cap_addr = '0;
		outcome = smap_pkg::OC_PENDING;
	endfunction

	function automatic smap_pkg::out_t close_message(input smap_pkg::status_t st);
		smap_pkg::out_t r;
		r.status = st;
		r.public_address = (st == smap_pkg::ST_FOUND) ? cap_addr : 32'd0;
		r.mapped_port = (st == smap_pkg::ST_FOUND) ? cap_port : 16'd0;
		phase = smap_pkg::PH_IDLE;
		return r;
	endfunction

	function automatic bit parse_byte(input smap_pkg::in_t req, output smap_pkg::out_t res);
		logic [7:0] d;
		logic [12:0] cap;
		int unsigned b, pos, room, span;
		bit halt;
		d = req.data_byte;
		res = '0;
		halt = 1'b0;
		if (req.first_byte) begin
			clear_message();
			phase = smap_pkg::PH_HEADER;
		end
		if (phase == smap_pkg::PH_HEADER) begin
			case (byte_pos)
				13'd2: body_len = {d, 8'h00};
				13'd3: body_len[7:0] = d;
				13'd4, 13'd5, 13'd6, 13'd7: cookie = {cookie[23:0], d};
				default: ;
			endcase
			if (byte_pos + 1 < smap_pkg::HEADER_BYTES) begin
				byte_pos = byte_pos + 1'b1;
				return 1'b0;
			end
			cap = (limit > smap_pkg::BODY_LIMIT) ? smap_pkg::BODY_LIMIT : limit;
			if (body_len == 16'd0 || body_len > {3'b000, cap}) begin
				res = close_message(smap_pkg::ST_BAD_LENGTH);
				return 1'b1;
			end
			phase = smap_pkg::PH_BODY;
			byte_pos = '0;
			attr_pos = '0;
			outcome = smap_pkg::OC_PENDING;
			return 1'b0;
		end
		if (phase != smap_pkg::PH_BODY)
			return 1'b0;
		b = 32'(byte_pos);
		if (outcome == smap_pkg::OC_PENDING) begin
			pos = 32'(attr_pos);
			room = 32'(body_len) - b;
			if (pos == 0 && room < 4) begin
				outcome = smap_pkg::OC_NONE;
			end else begin
				case (pos)
					0: attr_type = {d, 8'h00};
					1: attr_type[7:0] = d;
					2: attr_len = {d, 8'h00};
					3: begin
						attr_len[7:0] = d;
						if (32'(attr_len) > room - 1) begin
							outcome = smap_pkg::OC_OVERRUN;
							halt = 1'b1;
						end
					end
					5: if (d != smap_pkg::FAMILY_IPV4) attr_type = '0;
					6: cap_port = {d, 8'h00};
					7: cap_port[7:0] = d;
					8, 9, 10, 11: cap_addr = {cap_addr[23:0], d};
					default: ;
				endcase
				if (!halt) begin
					if (pos == 11 && attr_len >= 16'd8
							&& (attr_type == smap_pkg::TYPE_MAPPED
							|| attr_type == smap_pkg::TYPE_XOR_MAPPED)) begin
						if (attr_type == smap_pkg::TYPE_XOR_MAPPED) begin
							cap_port = cap_port ^ smap_pkg::MAGIC_COOKIE[31:16];
							cap_addr = cap_addr ^ cookie;
						end
						outcome = smap_pkg::OC_FOUND;
					end else if (pos >= 3) begin
						span = 4 + ((32'(attr_len) + 3) & ~32'd3);
						attr_pos = (pos + 1 >= span) ? 16'd0 : 16'(pos + 1);
					end else begin
						attr_pos = 16'(pos + 1);
					end
				end
			end
		end
		if (b + 1 >= 32'(body_len)) begin
			case (outcome)
				smap_pkg::OC_FOUND: res = close_message(smap_pkg::ST_FOUND);
				smap_pkg::OC_OVERRUN: res = close_message(smap_pkg::ST_OVERRUN);
				default: res = close_message(smap_pkg::ST_NONE);
			endcase
			return 1'b1;
		end
		byte_pos = 13'(b + 1);
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		smap_pkg::out_t want;
		if (!arst_n) begin
			clear_message();
			phase = smap_pkg::PH_IDLE;
			limit = smap_pkg::BODY_LIMIT;
			parsed_results.delete();
			pending_results <= 0;
			error_count <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				limit = cfg_data;
			if (out_valid && out_ready) begin
				if (parsed_results.size() == 0) begin
					$display("%0t: no result expected, got status %0d address %h port %h",
						$time, out_data.status, out_data.public_address,
						out_data.mapped_port);
					error_count <= error_count + 1;
				end else begin
					want = parsed_results.pop_front();
					if (out_data.status !== want.status
							|| out_data.public_address !== want.public_address
							|| out_data.mapped_port !== want.mapped_port) begin
						$display("%0t: expected status %0d address %h port %h", $time,
							want.status, want.public_address, want.mapped_port);
						$display("%0t: got      status %0d address %h port %h", $time,
							out_data.status, out_data.public_address, out_data.mapped_port);
						error_count <= error_count + 1;
					end
					results_checked <= results_checked + 1;
				end
			end
			if (in_valid && in_ready) begin
				if (parse_byte(in_data, want))
					parsed_results.insert(parsed_results.size(), want);
			end
			pending_results <= parsed_results.size();
		end
	end

endmodule

/* verif/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 40000;
	localparam int PHASE_BYTES = 150;
	localparam logic [15:0] TYPE_OTHER = 16'h8022;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	smap_pkg::in_t   in_data = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	smap_pkg::out_t  out_data;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [12:0]     cfg_data = '0;

	int pending_results;
	int error_count;
	int results_checked;
	int cycle_count = 0;
	int in_idle_pct = 14;
	int out_idle_pct = 14;
	int holds_asked = 0;
	int holds_done = 0;
	int hold_left = 0;
	int eff_limit = 4096;
	int bytes_sent = 0;
	int messages_sent = 0;
	int limits_written = 0;
	logic [7:0] body_q[$];

	stun_mapped_address_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	smap_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.pending_results (pending_results),
		.error_count     (error_count),
		.results_checked (results_checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (holds_done != holds_asked) begin
			holds_done <= holds_done + 1;
			hold_left <= 150;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic first);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: d, first_byte: first};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic add_byte(input logic [7:0] value);
		body_q.insert(body_q.size(), value);
	endtask

	task automatic add_attr(input logic [15:0] kind, input int len, input logic [7:0] family);
		int i;
		add_byte(kind[15:8]);
		add_byte(kind[7:0]);
		add_byte(len[15:8]);
		add_byte(len[7:0]);
		for (i = 0; i < len; i++)
			add_byte((i == 1) ? family : 8'($urandom_range(0, 255)));
		while (body_q.size() % 4 != 0)
			add_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_message(input logic [15:0] len_field, input int cut);
		logic [7:0] hdr [20];
		logic [31:0] magic;
		int total, i;
		magic = ($urandom_range(0, 3) != 0) ? smap_pkg::MAGIC_COOKIE : 32'($urandom);
		for (i = 0; i < 20; i++)
			hdr[i] = 8'($urandom_range(0, 255));
		hdr[2] = len_field[15:8];
		hdr[3] = len_field[7:0];
		for (i = 0; i < 4; i++)
			hdr[4 + i] = magic[31 - 8 * i -: 8];
		total = smap_pkg::HEADER_BYTES;
		if (len_field != 0 && len_field <= eff_limit)
			total += int'(len_field);
		if (cut > 0 && cut < total)
			total = cut;
		for (i = 0; i < total; i++) begin
			if (i < 20)
				send_byte(hdr[i], i == 0);
			else if (i - 20 < body_q.size())
				send_byte(body_q[i - 20], 1'b0);
			else
				send_byte(8'($urandom_range(0, 255)), 1'b0);
		end
		body_q.delete();
		messages_sent++;
	endtask

	task automatic random_message();
		int n, i, sel, cut;
		logic [15:0] kind;
		logic [15:0] len_field;
		if ($urandom_range(0, 99) < 5)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
		n = $urandom_range(0, 3);
		for (i = 0; i < n; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				add_attr(($urandom_range(0, 1) != 0) ?
						smap_pkg::TYPE_XOR_MAPPED : smap_pkg::TYPE_MAPPED,
					($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : 8,
					($urandom_range(0, 9) == 0) ?
						8'($urandom_range(0, 255)) : smap_pkg::FAMILY_IPV4);
			end else if (sel == 4) begin
				add_attr(($urandom_range(0, 1) != 0) ?
						smap_pkg::TYPE_XOR_MAPPED : smap_pkg::TYPE_MAPPED,
					$urandom_range(4, 7), smap_pkg::FAMILY_IPV4);
			end else begin
				do
					kind = 16'($urandom_range(0, 65535));
				while (sel < 9 && (kind == smap_pkg::TYPE_MAPPED
						|| kind == smap_pkg::TYPE_XOR_MAPPED));
				add_attr(kind, $urandom_range(0, 12), 8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
		len_field = 16'(body_q.size());
		sel = $urandom_range(0, 99);
		if (sel < 8)
			len_field = 16'(len_field + $urandom_range(1, 8));
		else if (sel < 14 && len_field > 4)
			len_field = 16'(len_field - $urandom_range(1, 4));
		else if (sel < 17)
			len_field = 16'd0;
		else if (sel < 20)
			len_field = 16'($urandom_range(4097, 65535));
		cut = ($urandom_range(0, 99) < 6) ? $urandom_range(1, 24 + body_q.size()) : -1;
		send_message(len_field, cut);
	endtask

	task automatic write_limit(input logic [12:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		eff_limit = int'((value > smap_pkg::BODY_LIMIT) ? smap_pkg::BODY_LIMIT : value);
		limits_written++;
	endtask

	initial begin
		logic [12:0] settings [7];
		int p, phase_start;
		settings = '{13'd0, 13'd1, 13'd8191, 13'd4097, 13'd24, 13'd0, 13'd4096};
		settings[5] = 13'($urandom_range(8, 80));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		write_limit(13'd4096);

		// Stray bytes while idle are dropped by the parser.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		add_attr(smap_pkg::TYPE_XOR_MAPPED, 8, smap_pkg::FAMILY_IPV4);
		send_message(16'(body_q.size()), -1);
		add_attr(TYPE_OTHER, 5, 8'h00);
		add_attr(smap_pkg::TYPE_MAPPED, 8, smap_pkg::FAMILY_IPV4);
		send_message(16'(body_q.size()), -1);
		add_attr(smap_pkg::TYPE_MAPPED, 8, 8'h02);
		add_attr(smap_pkg::TYPE_XOR_MAPPED, 12, smap_pkg::FAMILY_IPV4);
		send_message(16'(body_q.size()), -1);
		add_attr(smap_pkg::TYPE_MAPPED, 4, smap_pkg::FAMILY_IPV4);
		send_message(16'(body_q.size()), -1);
		add_attr(TYPE_OTHER, 4, 8'h00);
		repeat (3) add_byte(8'($urandom_range(0, 255)));
		send_message(16'(body_q.size()), -1);
		add_attr(TYPE_OTHER, 20, 8'h00);
		send_message(16'd12, -1);
		add_attr(smap_pkg::TYPE_XOR_MAPPED, 8, smap_pkg::FAMILY_IPV4);
		add_attr(TYPE_OTHER, 40, 8'h00);
		send_message(16'd24, -1);
		add_attr(TYPE_OTHER, 5, 8'h00);
		send_message(16'd9, -1);
		add_attr(TYPE_OTHER, 0, 8'h00);
		send_message(16'd4, -1);
		send_message(16'd0, -1);
		send_message(16'hFFFF, -1);
		send_message(16'd4097, -1);
		add_attr(smap_pkg::TYPE_XOR_MAPPED, 8, smap_pkg::FAMILY_IPV4);
		send_message(16'd12, 27);
		send_message(16'd12, 7);
		add_attr(smap_pkg::TYPE_MAPPED, 8, smap_pkg::FAMILY_IPV4);
		send_message(16'd12, -1);

		for (p = 0; p < 7; p++) begin
			write_limit(settings[p]);
			if (p == 0)
				holds_asked <= holds_asked + 1;
			in_idle_pct = (p == 2) ? 0 : 14;
			out_idle_pct <= (p == 2) ? 0 : 14;
			if (eff_limit <= 80) begin
				send_message(16'(eff_limit), -1);
				send_message(16'(eff_limit + 1), -1);
			end
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES)
				random_message();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes in %0d messages under %0d limit settings;", bytes_sent,
			messages_sent, limits_written);
		$display("%0d status results checked, with long output stalls and idle-free stretches.",
			results_checked);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
hdl/smap_pkg.sv
hdl/stun_mapped_address_parser.sv
verif/smap_checker.sv
verif/tb_top.sv
